/* sv/chat_message_deframer_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the chat message deframer.
// ---------------------------------------------------------------------------
`ifndef CHAT_MESSAGE_DEFRAMER_UNIT_ASSERT_SVH
`define CHAT_MESSAGE_DEFRAMER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMDF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("deframer assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define CMDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("deframer assertion failed: next-cycle check");

`endif

/* sv/cmdf_pkg.sv */
// ---------------------------------------------------------------------------
// cmdf_pkg
// Shared types and constants of the chat message deframer.
// ---------------------------------------------------------------------------
package cmdf_pkg;

	// Input actions
	localparam logic [1:0] ACT_BYTE       = 2'd0;
	localparam logic [1:0] ACT_DISCONNECT = 2'd1;

	// Result kinds
	localparam logic [1:0] KIND_DATA      = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_ERROR     = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_BAD_HEADER = 2'd0;
	localparam logic [1:0] ERR_MALFORMED  = 2'd1;
	localparam logic [1:0] ERR_DISCONNECT = 2'd2;

	localparam logic [7:0]  BAR_CHAR         = 8'h7C;
	localparam logic [7:0]  VERSION_CHAR     = 8'h31;
	localparam logic [7:0]  DIGIT_LO         = 8'h30;
	localparam logic [7:0]  DIGIT_HI         = 8'h39;
	localparam logic [2:0]  VERSION_CHARS    = 3'd7;
	localparam logic [2:0]  CODE_CHARS       = 3'd3;
	localparam int          NUM_CODES        = 5;
	localparam logic [23:0] BODY_LIMIT_RESET = 24'd100000;

	// NAM, SET, MSG, WHO, ERR
	localparam logic [23:0] CODE_WORDS [NUM_CODES] = '{
		24'h4E414D, 24'h534554, 24'h4D5347, 24'h57484F, 24'h455252
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] field;
		logic [2:0] code;
		logic [1:0] err;
		logic       last;
	} rslt_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} code_match_t;

	function automatic code_match_t code_lookup(input logic [23:0] word);
		code_match_t m;
		m = '0;
		for (int i = NUM_CODES - 1; i >= 0; i--) begin
			if (word == CODE_WORDS[i]) begin
				m.hit = 1'b1;
				m.idx = 3'(i);
			end
		end
		return m;
	endfunction

endpackage

/* sv/cmdf_front.sv */
// ---------------------------------------------------------------------------
// cmdf_front
// Accepts stream words, parses the header and tracks the body, and pushes
// one classified result per word that causes one.
// ---------------------------------------------------------------------------
`include "chat_message_deframer_unit_assert.svh"

module cmdf_front #(
	parameter int MAX_BODY_FIELDS = 4,
	parameter int LENGTH_DIGITS   = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [7:0]           data_byte,
	input  logic [23:0]          body_limit,
	input  logic                 q_full,
	output logic                 push,
	output cmdf_pkg::rslt_t      push_rec
);

	localparam int CW = $clog2(MAX_BODY_FIELDS + 1);

	typedef enum logic [1:0] {PH_VERSION, PH_CODE, PH_LENGTH, PH_BODY} phase_t;

	phase_t        phase_q, nx_phase;
	logic [2:0]    hc_q, nx_hc;
	logic          vok_q, nx_vok;
	logic [23:0]   cc_q, nx_cc;
	logic [23:0]   accum_q, nx_accum;
	logic          dok_q, nx_dok;
	logic [23:0]   rem_q, nx_rem;
	logic [CW-1:0] cf_q, nx_cf;
	logic [2:0]    ci_q, nx_ci;

	logic                  accept;
	logic                  emit;
	logic                  fail;
	logic                  restart;
	logic [1:0]            fail_ec;
	logic                  is_bar;
	logic                  is_digit;
	logic [23:0]           rem_dec;
	cmdf_pkg::code_match_t cmatch;
	cmdf_pkg::rslt_t       rec;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign is_bar   = (data_byte == cmdf_pkg::BAR_CHAR);
	assign is_digit = (data_byte >= cmdf_pkg::DIGIT_LO) && (data_byte <= cmdf_pkg::DIGIT_HI);
	assign rem_dec  = rem_q - 24'd1;
	assign cmatch   = cmdf_pkg::code_lookup(cc_q);

	always_comb begin
		nx_phase = phase_q;
		nx_hc    = hc_q;
		nx_vok   = vok_q;
		nx_cc    = cc_q;
		nx_accum = accum_q;
		nx_dok   = dok_q;
		nx_rem   = rem_q;
		nx_cf    = cf_q;
		nx_ci    = ci_q;
		emit     = 1'b0;
		fail     = 1'b0;
		restart  = 1'b0;
		fail_ec  = cmdf_pkg::ERR_MALFORMED;
		rec      = '0;

		priority if (action == cmdf_pkg::ACT_DISCONNECT) begin
			fail    = 1'b1;
			fail_ec = cmdf_pkg::ERR_DISCONNECT;
		end else if (action != cmdf_pkg::ACT_BYTE) begin
			fail = 1'b1;
		end else begin
			unique case (phase_q)
				PH_VERSION: begin
					if (is_bar) begin
						if (hc_q == 3'd1 && vok_q) begin
							nx_phase = PH_CODE;
							nx_hc    = '0;
							nx_cc    = '0;
						end else begin
							fail    = 1'b1;
							fail_ec = cmdf_pkg::ERR_BAD_HEADER;
						end
					end else if (hc_q >= cmdf_pkg::VERSION_CHARS) begin
						fail = 1'b1;
					end else begin
						nx_vok = (hc_q == 3'd0) && (data_byte == cmdf_pkg::VERSION_CHAR);
						nx_hc  = hc_q + 3'd1;
					end
				end
				PH_CODE: begin
					if (is_bar) begin
						if (hc_q == cmdf_pkg::CODE_CHARS && cmatch.hit) begin
							nx_ci    = cmatch.idx;
							nx_phase = PH_LENGTH;
							nx_hc    = '0;
							nx_accum = '0;
							nx_dok   = 1'b1;
						end else begin
							fail    = 1'b1;
							fail_ec = cmdf_pkg::ERR_BAD_HEADER;
						end
					end else if (hc_q >= cmdf_pkg::CODE_CHARS) begin
						fail = 1'b1;
					end else begin
						nx_cc = {cc_q[15:0], data_byte};
						nx_hc = hc_q + 3'd1;
					end
				end
				PH_LENGTH: begin
					if (is_bar) begin
						if (!dok_q || accum_q == 24'd0 || accum_q >= body_limit) begin
							fail = 1'b1;
						end else begin
							nx_phase = PH_BODY;
							nx_rem   = accum_q;
							nx_cf    = '0;
							nx_hc    = '0;
						end
					end else if (hc_q >= 3'(LENGTH_DIGITS)) begin
						fail = 1'b1;
					end else begin
						// Times ten as two shifts and an add, wrapping at 24 bits.
						if (is_digit)
							nx_accum = (accum_q << 3) + (accum_q << 1) + 24'(data_byte[3:0]);
						else
							nx_dok = 1'b0;
						nx_hc = hc_q + 3'd1;
					end
				end
				PH_BODY: begin
					if (cf_q >= CW'(MAX_BODY_FIELDS)) begin
						fail = 1'b1;
					end else begin
						nx_rem     = rem_dec;
						rec.field  = 2'(cf_q);
						rec.code   = ci_q;
						if (is_bar) begin
							emit     = 1'b1;
							rec.kind = cmdf_pkg::KIND_FIELD_END;
							if (rem_dec == 24'd0) begin
								restart  = 1'b1;
								rec.last = 1'b1;
							end else begin
								nx_cf = cf_q + CW'(1);
							end
						end else if (rem_dec == 24'd0) begin
							// Body ran out without a closing bar.
							fail = 1'b1;
						end else begin
							emit     = 1'b1;
							rec.kind = cmdf_pkg::KIND_DATA;
							rec.data = data_byte;
						end
					end
				end
				default: ;
			endcase
		end

		if (fail) begin
			restart  = 1'b1;
			emit     = 1'b1;
			rec      = '0;
			rec.kind = cmdf_pkg::KIND_ERROR;
			rec.err  = fail_ec;
		end

		if (restart) begin
			nx_phase = PH_VERSION;
			nx_hc    = '0;
			nx_vok   = 1'b0;
			nx_cc    = '0;
			nx_accum = '0;
			nx_dok   = 1'b1;
			nx_rem   = '0;
			nx_cf    = '0;
			nx_ci    = '0;
		end
	end

	assign push     = accept && emit;
	assign push_rec = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERSION;
			hc_q    <= '0;
			vok_q   <= 1'b0;
			cc_q    <= '0;
			accum_q <= '0;
			dok_q   <= 1'b1;
			rem_q   <= '0;
			cf_q    <= '0;
			ci_q    <= '0;
		end else if (accept) begin
			phase_q <= nx_phase;
			hc_q    <= nx_hc;
			vok_q   <= nx_vok;
			cc_q    <= nx_cc;
			accum_q <= nx_accum;
			dok_q   <= nx_dok;
			rem_q   <= nx_rem;
			cf_q    <= nx_cf;
			ci_q    <= nx_ci;
		end
	end

	`CMDF_ASSERT_NEXT(a_error_restarts, clk, arst_n, push && push_rec.kind == cmdf_pkg::KIND_ERROR, phase_q == PH_VERSION && hc_q == 3'd0)
	`CMDF_ASSERT_SAME(a_field_bound, clk, arst_n, 1'b1, (phase_q == PH_BODY && cf_q <= CW'(MAX_BODY_FIELDS)) || (phase_q != PH_BODY && cf_q == '0))

endmodule

/* sv/cmdf_queue.sv */
// ---------------------------------------------------------------------------
// cmdf_queue
// Two-entry result queue between the parser and the output stage.
// ---------------------------------------------------------------------------
`include "chat_message_deframer_unit_assert.svh"

module cmdf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cmdf_pkg::rslt_t push_rec,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output cmdf_pkg::rslt_t head
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	cmdf_pkg::rslt_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;

	assign full      = (count_q == NW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`CMDF_ASSERT_SAME(a_no_overflow, clk, arst_n, push, !full)
	`CMDF_ASSERT_SAME(a_no_underflow, clk, arst_n, pop, not_empty)

endmodule

/* sv/cmdf_back.sv */
// ---------------------------------------------------------------------------
// cmdf_back
// Output stage: draws results from the queue into a registered output.
// ---------------------------------------------------------------------------
module cmdf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  cmdf_pkg::rslt_t q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte,
	output logic [1:0]      field_index,
	output logic [2:0]      msg_code,
	output logic [1:0]      error_code,
	output logic            last
);

	logic            out_valid_q;
	cmdf_pkg::rslt_t out_rec_q;

	// Refill whenever the register is empty or its word leaves this cycle.
	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || out_ready)
			out_valid_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			out_rec_q <= q_head;
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_rec_q.kind;
	assign out_byte    = out_rec_q.data;
	assign field_index = out_rec_q.field;
	assign msg_code    = out_rec_q.code;
	assign error_code  = out_rec_q.err;
	assign last        = out_rec_q.last;

endmodule

/* sv/chat_message_deframer_unit.sv */
// ---------------------------------------------------------------------------
// chat_message_deframer_unit
// Deframes a version|code|length|body byte stream into tagged body and error results.
// ---------------------------------------------------------------------------
// The unit takes one input word per clock cycle when the output side keeps
// up: the header and body state machine in the front end classifies each
// word combinationally, including the times-ten length update and the
// limit compare. A result passes from its accepted input word through a
// two-entry queue and then an output register, so the input keeps accepting
// while a result waits to be taken; the input stalls only when the queue is
// full. Words that cause no result (header bytes and header delimiters) are
// consumed without a push to the queue. The body_limit register may be
// written at any time the block is idle and its write channel is always
// ready.
module chat_message_deframer_unit #(
	parameter int MAX_BODY_FIELDS = 4,
	parameter int LENGTH_DIGITS   = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] body_limit,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [1:0]  field_index,
	output logic [2:0]  msg_code,
	output logic [1:0]  error_code,
	output logic        last
);

	logic [23:0]     body_limit_q;
	logic            push;
	cmdf_pkg::rslt_t push_rec;
	logic            q_full;
	logic            q_not_empty;
	logic            q_pop;
	cmdf_pkg::rslt_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			body_limit_q <= cmdf_pkg::BODY_LIMIT_RESET;
		else if (cfg_valid && cfg_ready)
			body_limit_q <= body_limit;
	end

	cmdf_front #(
		.MAX_BODY_FIELDS(MAX_BODY_FIELDS),
		.LENGTH_DIGITS  (LENGTH_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.data_byte (data_byte),
		.body_limit(body_limit_q),
		.q_full    (q_full),
		.push      (push),
		.push_rec  (push_rec)
	);

	cmdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	cmdf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_byte   (out_byte),
		.field_index(field_index),
		.msg_code   (msg_code),
		.error_code (error_code),
		.last       (last)
	);

endmodule
